@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checking off while reset is high
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checking off while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mbe_pkg.sv @@
`default_nettype none

package mbe_pkg;

  // image geometry and number format
  localparam int IMG_WIDTH  = 1024;
  localparam int IMG_HEIGHT = 1024;
  localparam int HALF_W     = IMG_WIDTH / 2;
  localparam int HALF_H     = IMG_HEIGHT / 2;
  localparam int FRAC_BITS  = 26;

  localparam logic [63:0] ESC_LIMIT = 64'd1 << (2 * FRAC_BITS + 2);

  // register reset values
  localparam logic [31:0] CENTER_RE_RST = 32'hFE00_0000;
  localparam logic [31:0] CENTER_IM_RST = 32'h0000_0000;
  localparam logic [30:0] STEP_RST      = 31'd196608;
  localparam logic [15:0] MAX_ITER_RST  = 16'd128;

  // register indexes on the config port
  typedef enum logic [2:0] {
    CFG_CENTER_RE = 3'd0,
    CFG_CENTER_IM = 3'd1,
    CFG_STEP_RE   = 3'd2,
    CFG_STEP_IM   = 3'd3,
    CFG_MAX_ITER  = 3'd4
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_RE,
    ST_MAP_IM,
    ST_MAP_END,
    ST_CALC,
    ST_MUL_RR,
    ST_MUL_II,
    ST_MUL_RI
  } state_t;

  // operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MS_ZERO,
    MS_MAP_RE,
    MS_MAP_IM,
    MS_RR,
    MS_II,
    MS_RI
  } mul_sel_t;

  // sequencer to datapath
  typedef struct packed {
    mul_sel_t mul_sel;
    logic     take;
    logic     ld_c_re;
    logic     ld_c_im;
    logic     ld_rr;
    logic     ld_ii;
    logic     step_z;
    logic     ld_out;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic esc_hit;
    logic lim_hit;
    logic out_free;
  } stat_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mbe_mul.sv @@
`default_nettype none

module mbe_mul (
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [63:0]      p
);

  // one signed 32x32 product per cycle, registered
  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

`default_nettype wire

@@ rtl/mbe_fsm.sv @@
`default_nettype none

module mbe_fsm (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire mbe_pkg::stat_t stat,
  output mbe_pkg::ctrl_t      ctrl
);

  import mbe_pkg::*;

  state_t state;
  state_t state_next;
  logic   finish;

  assign finish = stat.esc_hit || stat.lim_hit;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_MAP_RE;
      ST_MAP_RE:  state_next = ST_MAP_IM;
      ST_MAP_IM:  state_next = ST_MAP_END;
      ST_MAP_END: state_next = ST_CALC;
      ST_CALC: begin
        if (!finish) begin
          state_next = ST_MUL_RR;
        end else if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL_RR:  state_next = ST_MUL_II;
      ST_MUL_II:  state_next = ST_MUL_RI;
      ST_MUL_RI:  state_next = ST_CALC;
      default:    state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl = '0;
    ctrl.mul_sel = MS_ZERO;
    unique case (state)
      ST_IDLE:    ctrl.take = 1'b1;
      ST_MAP_RE:  ctrl.mul_sel = MS_MAP_RE;
      ST_MAP_IM: begin
        ctrl.mul_sel = MS_MAP_IM;
        ctrl.ld_c_re = 1'b1;
      end
      ST_MAP_END: ctrl.ld_c_im = 1'b1;
      ST_CALC: begin
        ctrl.step_z = !finish;
        ctrl.ld_out = finish && stat.out_free;
      end
      ST_MUL_RR:  ctrl.mul_sel = MS_RR;
      ST_MUL_II: begin
        ctrl.mul_sel = MS_II;
        ctrl.ld_rr   = 1'b1;
      end
      ST_MUL_RI: begin
        ctrl.mul_sel = MS_RI;
        ctrl.ld_ii   = 1'b1;
      end
      default: ctrl.mul_sel = MS_ZERO;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/mandelbrot_escape_time.sv @@
// one item at a time, up to max_iter iterations per item; each iteration runs three
//   products on the single shared 32x32 multiplier plus one update step
// reset: synchronous, clears the sequencer and the output valid, loads register defaults
// the next input item is taken while a finished result still waits in the output register
`default_nettype none

module mandelbrot_escape_time (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // pixel_x[9:0], pixel_y[19:10], zero fill
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // iter_count[15:0]
  output logic             m_axis_tuser,   // escaped[0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  import mbe_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  logic signed [31:0] center_re;
  logic signed [31:0] center_im;
  logic [30:0]        step_re;
  logic [30:0]        step_im;
  logic [15:0]        max_iter;

  logic [9:0]         px;
  logic [9:0]         py;
  logic signed [31:0] off_x;
  logic signed [31:0] off_y;
  logic signed [31:0] c_re;
  logic signed [31:0] c_im;
  logic signed [31:0] zr;
  logic signed [31:0] zi;
  logic signed [63:0] rr;
  logic signed [63:0] ii;
  logic [15:0]        iter;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;

  logic signed [63:0] diff;
  logic signed [31:0] nr;
  logic signed [31:0] ni;
  logic [63:0]        mag;

  // config port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_re <= CENTER_RE_RST;
      center_im <= CENTER_IM_RST;
      step_re   <= STEP_RST;
      step_im   <= STEP_RST;
      max_iter  <= MAX_ITER_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CENTER_RE: center_re <= cfg_data;
        CFG_CENTER_IM: center_im <= cfg_data;
        CFG_STEP_RE:   step_re   <= cfg_data[30:0];
        CFG_STEP_IM:   step_im   <= cfg_data[30:0];
        CFG_MAX_ITER:  max_iter  <= cfg_data[15:0];
        default:       ;
      endcase
    end
  end

  // sequencer
  mbe_fsm u_fsm (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  assign s_axis_tready = ctrl.take;

  // capture the pixel coordinate
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      px <= s_axis_tdata[9:0];
      py <= s_axis_tdata[19:10];
    end
  end

  assign off_x = $signed({22'd0, px}) - $signed(32'(HALF_W));
  assign off_y = $signed({22'd0, py}) - $signed(32'(HALF_H));

  // operand select for the shared multiplier
  always_comb begin
    unique case (ctrl.mul_sel)
      MS_MAP_RE: begin
        mul_a = $signed({1'b0, step_re});
        mul_b = off_x;
      end
      MS_MAP_IM: begin
        mul_a = $signed({1'b0, step_im});
        mul_b = off_y;
      end
      MS_RR: begin
        mul_a = zr;
        mul_b = zr;
      end
      MS_II: begin
        mul_a = zi;
        mul_b = zi;
      end
      MS_RI: begin
        mul_a = zr;
        mul_b = zi;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mbe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // next iterate from the squares and the cross product (prod holds zr*zi here)
  assign diff = rr - ii;
  assign nr   = sat32((diff >>> FRAC_BITS) + 64'(c_re));
  assign ni   = sat32((prod >>> (FRAC_BITS - 1)) + 64'(c_im));

  // squares of the last iterate give its squared magnitude
  assign mag = $unsigned(rr) + $unsigned(ii);

  assign stat.esc_hit  = (iter != '0) && (mag > ESC_LIMIT);
  assign stat.lim_hit  = (iter == max_iter);
  assign stat.out_free = !m_axis_tvalid || m_axis_tready;

  // iteration state
  always_ff @(posedge clk) begin
    if (ctrl.ld_c_re) begin
      c_re <= sat32(prod + 64'(center_re));
    end
    if (ctrl.ld_c_im) begin
      c_im <= sat32(prod + 64'(center_im));
      zr   <= '0;
      zi   <= '0;
      rr   <= '0;
      ii   <= '0;
      iter <= '0;
    end
    if (ctrl.ld_rr) begin
      rr <= prod;
    end
    if (ctrl.ld_ii) begin
      ii <= prod;
    end
    if (ctrl.step_z) begin
      zr   <= nr;
      zi   <= ni;
      iter <= iter + 16'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctrl.ld_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      m_axis_tdata <= stat.esc_hit ? (iter - 16'd1) : iter;
      m_axis_tuser <= stat.esc_hit;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mbe_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module mbe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  logic s_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  // one item in flight: input closes right after an accept
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, s_acc, !s_axis_tready, "input open while busy")

  // a result never follows its item in the next cycle
  `ASSERT_IMPLY(a_no_fast_result, clk, rst, $rose(m_axis_tvalid), !$past(s_acc), "result too early")

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // register writes never stall
  `ASSERT_IMPLY(a_cfg_ready, clk, rst, cfg_valid, cfg_ready, "config write stalled")

endmodule

bind mandelbrot_escape_time mbe_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);

`default_nettype wire

@@ tb/mandelbrot_escape_time_tb.sv @@
`timescale 1ns / 100ps

module mandelbrot_escape_time_tb;
  import mbe_pkg::*;

  localparam int    PHASE_ITEMS = 173;
  localparam int    RAND_PHASES = 10;
  localparam int    HOLD_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 10_000_000;
  localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_MIN = -64'sh0000_0000_8000_0000;

  // one pending escape result, with the pixel that caused it
  typedef struct packed {
    logic [9:0]  px;
    logic [9:0]  py;
    logic [15:0] iters;
    logic        escaped;
  } escape_t;

  // view registers, escape-time predictor and queue of pending results
  class escape_tracker;
    logic signed [31:0] center_re;
    logic signed [31:0] center_im;
    logic [30:0]        step_re;
    logic [30:0]        step_im;
    logic [15:0]        max_iter;
    escape_t            expected_escapes[$];
    int                 errors;

    function new();
      center_re = CENTER_RE_RST;
      center_im = CENTER_IM_RST;
      step_re   = STEP_RST;
      step_im   = STEP_RST;
      max_iter  = MAX_ITER_RST;
      errors    = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] value);
      case (idx)
        CFG_CENTER_RE: center_re = value;
        CFG_CENTER_IM: center_im = value;
        CFG_STEP_RE:   step_re   = value[30:0];
        CFG_STEP_IM:   step_im   = value[30:0];
        CFG_MAX_ITER:  max_iter  = value[15:0];
        default: ;
      endcase
    endfunction

    function longint clamp_q626(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
    endfunction

    // map the pixel to c and run z = z*z + c from zero
    function escape_t escape_time(logic [9:0] px, logic [9:0] py);
      escape_t           r;
      longint            c_re, c_im, zr, zi, nr, ni;
      longint unsigned   ar, ai;
      int                n;
      c_re = clamp_q626(longint'(step_re) * (longint'(px) - HALF_W) + longint'(center_re));
      c_im = clamp_q626(longint'(step_im) * (longint'(py) - HALF_H) + longint'(center_im));
      zr = 0;
      zi = 0;
      n  = 0;
      r.px = px;
      r.py = py;
      r.escaped = 1'b0;
      while (n < int'(max_iter)) begin
        nr = clamp_q626(((zr * zr - zi * zi) >>> FRAC_BITS) + c_re);
        ni = clamp_q626(((zr * zi) >>> (FRAC_BITS - 1)) + c_im);
        ar = (nr < 0) ? -nr : nr;
        ai = (ni < 0) ? -ni : ni;
        zr = nr;
        zi = ni;
        // strict compare: a magnitude of exactly two stays in
        if (ar * ar + ai * ai > ESC_LIMIT) begin
          r.escaped = 1'b1;
          break;
        end
        n++;
      end
      r.iters = n[15:0];
      return r;
    endfunction

    function void note_pixel(logic [9:0] px, logic [9:0] py);
      expected_escapes.push_back(escape_time(px, py));
    endfunction

    function void check_result(logic [15:0] iters, logic escaped);
      escape_t want;
      if (expected_escapes.size() == 0) begin
        $display("%0t: unexpected result iter_count=%0d escaped=%0d", $time, iters, escaped);
        errors++;
        return;
      end
      want = expected_escapes.pop_front();
      if (iters !== want.iters) begin
        $display("%0t: iter_count mismatch pixel (%0d,%0d) expected %0d actual %0d",
                 $time, want.px, want.py, want.iters, iters);
        errors++;
      end
      if (escaped !== want.escaped) begin
        $display("%0t: escaped mismatch pixel (%0d,%0d) expected %0d actual %0d",
                 $time, want.px, want.py, want.escaped, escaped);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // pixel_x[9:0], pixel_y[19:10], zero fill
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // iter_count[15:0]
  logic        m_axis_tuser;   // escaped[0]
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_idx_t    cfg_index;
  logic [31:0] cfg_data;

  escape_tracker sb;
  int            idle_odds;
  bit            hold_request;
  longint        cycle_count;

  mandelbrot_escape_time u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mandelbrot_escape_time_tb: FAIL");
      $finish;
    end
  end

  // offer one pixel item, with an occasional gap ahead of it
  task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
    int gap;
    @(negedge clk);
    if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, py, px};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_pixel(px, py);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused upper bits of the narrow registers get random junk
  task automatic load_view(input logic [31:0] cre, input logic [31:0] cim,
                           input logic [30:0] sre, input logic [30:0] sim,
                           input logic [15:0] lim);
    write_reg(CFG_CENTER_RE, cre);
    write_reg(CFG_CENTER_IM, cim);
    write_reg(CFG_STEP_RE, {1'($urandom_range(0, 1)), sre});
    write_reg(CFG_STEP_IM, {1'($urandom_range(0, 1)), sim});
    write_reg(CFG_MAX_ITER, {16'($urandom()), lim});
  endtask

  // stop offering and wait for every pending result
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_escapes.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
        stall_left = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // stimulus
  initial begin
    logic [31:0] cre, cim;
    logic [30:0] sre, sim;
    logic [15:0] lim;
    int          zoom;
    clk           = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_CENTER_RE;
    cfg_data      = '0;
    idle_odds     = 15;
    hold_request  = 1'b0;
    cycle_count   = 0;
    sb            = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // default view: corners, edges, the center point and c = -2 on the boundary
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd512);
    send_pixel(10'd512, 10'd1023);
    send_pixel(10'd1023, 10'd512);
    drain();

    // zero limit: no iteration at all
    load_view(32'hFE00_0000, 32'h0000_0000, STEP_RST, STEP_RST, 16'd0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd1023, 10'd1023);
    drain();

    // mapped coordinates saturate at both limits
    load_view(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd3);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd1023, 10'd0);
    drain();

    // largest limit: only the origin stays in, the rest saturate and escape at once
    load_view(32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd1023, 10'd512);
    drain();

    // random views near the set, zoomed by a random power of two, one phase fully random
    for (int p = 0; p < RAND_PHASES; p++) begin
      zoom = $urandom_range(0, 12);
      cre  = $urandom_range(0, 167772160) - 134217728;
      cim  = $urandom_range(0, 167772160) - 83886080;
      sre  = 31'((31'd196608 >> zoom) + $urandom_range(0, 63));
      sim  = 31'((31'd196608 >> zoom) + $urandom_range(0, 63));
      lim  = 16'($urandom_range(2, 40));
      if (p == 2) lim = 16'd128;
      if (p == 3) begin
        cre = $urandom();
        cim = $urandom();
        sre = 31'($urandom());
        sim = 31'($urandom());
        lim = 16'($urandom_range(2, 20));
      end
      if (p == 4) lim = 16'd1;
      if (p == 5) lim = 16'($urandom_range(0, 3));
      if (p == 7) begin
        sre = '0;
        sim = '0;
      end
      load_view(cre, cim, sre, sim, lim);
      idle_odds = (p == 6 || p == RAND_PHASES - 1) ? 0 : $urandom_range(5, 35);
      // result side holds off so the block fills and stalls its input
      if (p == 1) hold_request = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_pixel(10'($urandom()), 10'($urandom()));
      end
      drain();
    end

    repeat (8 + 4 * int'(sb.max_iter)) @(posedge clk);
    if (sb.errors == 0) begin
      $display("mandelbrot_escape_time_tb: PASS");
    end else begin
      $display("mandelbrot_escape_time_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mbe_pkg.sv
rtl/mbe_mul.sv
rtl/mbe_fsm.sv
rtl/mandelbrot_escape_time.sv
rtl/mbe_checker.sv
tb/mandelbrot_escape_time_tb.sv
